@@ hw/rtl/fpa_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpa_pkg
// Shared types, operation codes and widths of the fixed-point ALU.
// ---------------------------------------------------------------------------
package fpa_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int WORD_W      = 32;
    localparam int KIND_W      = 4;
    localparam int DIV_W       = WORD_W + FRAC_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [KIND_W-1:0] KIND_ADD        = 4'd0;
    localparam logic [KIND_W-1:0] KIND_SUB        = 4'd1;
    localparam logic [KIND_W-1:0] KIND_MUL        = 4'd2;
    localparam logic [KIND_W-1:0] KIND_DIV        = 4'd3;
    localparam logic [KIND_W-1:0] KIND_CMP        = 4'd4;
    localparam logic [KIND_W-1:0] KIND_MIN        = 4'd5;
    localparam logic [KIND_W-1:0] KIND_MAX        = 4'd6;
    localparam logic [KIND_W-1:0] KIND_FROM_INT   = 4'd7;
    localparam logic [KIND_W-1:0] KIND_TO_INT     = 4'd8;
    localparam logic [KIND_W-1:0] KIND_FROM_FLOAT = 4'd9;
    localparam logic [KIND_W-1:0] KIND_TO_FLOAT   = 4'd10;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
        logic                     less;
        logic                     equal;
        logic                     greater;
        logic                     div_start;
        logic                     div_zero;
    } fpa_item_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [WORD_W-1:0] divisor;
        logic              negate;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [WORD_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ hw/rtl/fpa_req_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpa_req_if
// Request channel: operation code and two raw operands.
// ---------------------------------------------------------------------------
interface fpa_req_if;
    logic                                     valid;
    logic                                     ready;
    logic [fpa_pkg::KIND_W-1:0]               kind;
    logic signed [fpa_pkg::WORD_W-1:0]        operand_a;
    logic signed [fpa_pkg::WORD_W-1:0]        operand_b;

    modport source (output valid, output kind, output operand_a, output operand_b,
                    input ready);
    modport sink (input valid, input kind, input operand_a, input operand_b,
                  output ready);
endinterface

@@ hw/rtl/fpa_rsp_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpa_rsp_if
// Response channel: raw result word and compare / error flags.
// ---------------------------------------------------------------------------
interface fpa_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [fpa_pkg::WORD_W-1:0] result_word;
    logic                              less_flag;
    logic                              equal_flag;
    logic                              greater_flag;
    logic                              divide_by_zero;

    modport source (output valid, output result_word, output less_flag,
                    output equal_flag, output greater_flag, output divide_by_zero,
                    input ready);
    modport sink (input valid, input result_word, input less_flag,
                  input equal_flag, input greater_flag, input divide_by_zero,
                  output ready);
endinterface

@@ hw/rtl/fpa_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpa_front
// Accepts request transactions, computes the flags and classifies the op.
// ---------------------------------------------------------------------------
module fpa_front
(
    fpa_req_if.sink            request,
    input  logic               queue_full,
    output logic               push,
    output fpa_pkg::fpa_item_t item
);

    logic b_zero;

    assign request.ready = !queue_full;
    assign push          = request.valid && !queue_full;
    assign b_zero        = (request.operand_b == '0);

    always_comb
    begin
        item.kind      = request.kind;
        item.a         = request.operand_a;
        item.b         = request.operand_b;
        item.less      = (request.operand_a < request.operand_b);
        item.equal     = (request.operand_a == request.operand_b);
        item.greater   = (request.operand_a > request.operand_b);
        item.div_start = (request.kind == fpa_pkg::KIND_DIV) && !b_zero;
        item.div_zero  = (request.kind == fpa_pkg::KIND_DIV) && b_zero;
    end

endmodule

@@ hw/rtl/fpa_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpa_queue
// Short queue between the front and back parts.
// ---------------------------------------------------------------------------
module fpa_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  fpa_pkg::fpa_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output fpa_pkg::fpa_item_t head
);

    localparam int PTR_W = (fpa_pkg::QUEUE_DEPTH > 1) ? $clog2(fpa_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(fpa_pkg::QUEUE_DEPTH + 1);

    fpa_pkg::fpa_item_t entries_reg [fpa_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full  = (count_reg == CNT_W'(fpa_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(fpa_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(fpa_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hw/rtl/fpa_divider.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpa_divider
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ---------------------------------------------------------------------------
module fpa_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  fpa_pkg::div_req_t req,
    output fpa_pkg::div_rsp_t rsp
);

    localparam int DW = fpa_pkg::DIV_W;
    localparam int WW = fpa_pkg::WORD_W;

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [fpa_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WW:0]                   rem_reg, rem_next;
    logic [DW-1:0]                 quo_reg, quo_next;
    logic [WW-1:0]                 divisor_reg, divisor_next;
    logic                          neg_reg, neg_next;
    logic [WW:0]                   rem_shift;
    logic                          fits;
    logic [DW-1:0]                 quo_signed;

    assign rem_shift  = {rem_reg[WW-1:0], quo_reg[DW-1]};
    assign fits       = (rem_shift >= {1'b0, divisor_reg});
    assign quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_signed[WW-1:0];

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = done_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        neg_next     = neg_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            done_next    = 1'b0;
            cnt_next     = fpa_pkg::DIV_CNT_W'(DW);
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
            neg_next     = req.negate;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (rem_shift - {1'b0, divisor_reg}) : rem_shift;
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == fpa_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
        neg_reg     <= neg_next;
    end

endmodule

@@ hw/rtl/fpa_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpa_back
// Execution pipeline: operand stage, finishing stage and output register.
// ---------------------------------------------------------------------------
module fpa_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               queue_empty,
    input  fpa_pkg::fpa_item_t head,
    output logic               pop,
    fpa_rsp_if.source          response
);

    localparam int WW = fpa_pkg::WORD_W;
    localparam int F  = fpa_pkg::FRAC_BITS;

    // ieee single to fixed, half away from zero, saturating
    function automatic logic [WW-1:0] float_to_fixed(input logic [WW-1:0] bits);
        logic              sgn;
        logic [7:0]        ex;
        logic [7:0]        ex_eff;
        logic [23:0]       man;
        logic signed [9:0] sh;
        logic [9:0]        n;
        logic [55:0]       mag;
        logic [23:0]       part;
        logic [55:0]       limit;
        logic [WW-1:0]     res;
        sgn    = bits[31];
        ex     = bits[30:23];
        man    = {(ex != 8'd0), bits[22:0]};
        ex_eff = (ex == 8'd0) ? 8'd1 : ex;
        sh     = $signed({2'b00, ex_eff}) - 10'sd150 + 10'(F);
        n      = 10'(-sh);
        limit  = sgn ? 56'h80000000 : 56'h7FFFFFFF;
        part   = '0;
        if (sh >= 0)
        begin
            if (sh > 10'sd31)
            begin
                mag = limit;
            end
            else
            begin
                mag = {32'd0, man} << sh[4:0];
            end
        end
        else if (n > 10'd25)
        begin
            mag = '0;
        end
        else
        begin
            part = man >> (n[4:0] - 5'd1);
            mag  = 56'((25'(part) + 25'd1) >> 1);
        end
        if (mag > limit)
        begin
            mag = limit;
        end
        res = sgn ? (~mag[WW-1:0] + 1'b1) : mag[WW-1:0];
        if (ex == 8'hFF)
        begin
            res = (man[22:0] != '0) ? '0 : limit[WW-1:0];
        end
        else if (man == '0)
        begin
            res = '0;
        end
        return res;
    endfunction

    // first stage registers
    logic                          s1_valid_reg;
    logic [fpa_pkg::KIND_W-1:0]    s1_kind_reg;
    logic [WW-1:0]                 s1_word_reg;
    logic signed [2*WW-1:0]        s1_prod_reg;
    logic [WW-1:0]                 s1_mag_reg;
    logic [4:0]                    s1_msb_reg;
    logic                          s1_sign_reg;
    logic                          s1_less_reg, s1_equal_reg, s1_greater_reg;
    logic                          s1_dz_reg;
    // output register
    logic                          rsp_valid_reg;
    logic [WW-1:0]                 rsp_word_reg;
    logic                          rsp_less_reg, rsp_equal_reg, rsp_greater_reg;
    logic                          rsp_dz_reg;

    fpa_pkg::div_req_t div_req;
    fpa_pkg::div_rsp_t div_rsp;

    logic          out_free;
    logic          s1_done;
    logic          s1_move;
    logic          s1_load;
    logic [WW-1:0] word_a;
    logic [WW-1:0] mag_a;
    logic [4:0]    msb_a;
    logic [WW-1:0] word_b;
    logic [WW-1:0] float_b;
    logic [2*WW-1:0] prod_shift;
    logic [4:0]    nsh;
    logic [WW-1:0] q_trunc;
    logic [WW-1:0] rem_bits;
    logic [WW-1:0] half;
    logic          round_up;
    logic [24:0]   q_pre;
    logic [23:0]   q_fin;
    logic          carry;
    logic [8:0]    expo;

    assign out_free = !rsp_valid_reg || response.ready;
    assign s1_done  = (s1_kind_reg != fpa_pkg::KIND_DIV) || s1_dz_reg
                      || (div_rsp.done && !div_rsp.busy);
    assign s1_move  = s1_valid_reg && s1_done && out_free;
    assign s1_load  = !queue_empty && (!s1_valid_reg || s1_move);
    assign pop      = s1_load;

    // divider takes magnitudes, sign fixed on the way out
    always_comb
    begin
        div_req.start    = s1_load && head.div_start;
        div_req.dividend = fpa_pkg::DIV_W'(mag_a) << F;
        div_req.divisor  = head.b[WW-1] ? (~head.b + 1'b1) : head.b;
        div_req.negate   = head.a[WW-1] ^ head.b[WW-1];
    end

    fpa_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // first stage logic
    always_comb
    begin
        mag_a = head.a[WW-1] ? (~head.a + 1'b1) : head.a;
        msb_a = '0;
        for (int i = 0; i < WW; i++)
        begin
            if (mag_a[i])
            begin
                msb_a = 5'(i);
            end
        end
        case (head.kind)
            fpa_pkg::KIND_ADD:        word_a = head.a + head.b;
            fpa_pkg::KIND_SUB:        word_a = head.a - head.b;
            fpa_pkg::KIND_CMP:        word_a = head.less ? '1
                                               : (head.greater ? WW'(1) : '0);
            fpa_pkg::KIND_MIN:        word_a = head.less ? head.a : head.b;
            fpa_pkg::KIND_MAX:        word_a = head.less ? head.b : head.a;
            fpa_pkg::KIND_FROM_INT:   word_a = head.a << F;
            fpa_pkg::KIND_TO_INT:     word_a = head.a >>> F;
            fpa_pkg::KIND_FROM_FLOAT: word_a = float_to_fixed(head.a);
            default:                  word_a = '0;
        endcase
    end

    // fixed to single, nearest even
    always_comb
    begin
        nsh      = s1_msb_reg - 5'd23;
        q_trunc  = s1_mag_reg >> nsh;
        rem_bits = s1_mag_reg & ((WW'(1) << nsh) - WW'(1));
        half     = WW'(1) << (nsh - 5'd1);
        round_up = (rem_bits > half) || ((rem_bits == half) && q_trunc[0]);
        if (s1_msb_reg <= 5'd23)
        begin
            q_pre = 25'(s1_mag_reg << (5'd23 - s1_msb_reg));
        end
        else
        begin
            q_pre = q_trunc[24:0] + 25'(round_up);
        end
        carry = q_pre[24];
        q_fin = carry ? q_pre[24:1] : q_pre[23:0];
        expo  = 9'(s1_msb_reg) + 9'(carry) + 9'(127 - F);
        float_b = (s1_mag_reg == '0) ? '0 : {s1_sign_reg, expo[7:0], q_fin[22:0]};
    end

    // finishing stage
    always_comb
    begin
        prod_shift = s1_prod_reg >>> F;
        case (s1_kind_reg)
            fpa_pkg::KIND_MUL:      word_b = prod_shift[WW-1:0];
            fpa_pkg::KIND_DIV:      word_b = s1_dz_reg ? '0 : div_rsp.quotient;
            fpa_pkg::KIND_TO_FLOAT: word_b = float_b;
            default:                word_b = s1_word_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_kind_reg    <= head.kind;
            s1_word_reg    <= word_a;
            s1_prod_reg    <= head.a * head.b;
            s1_mag_reg     <= mag_a;
            s1_msb_reg     <= msb_a;
            s1_sign_reg    <= head.a[WW-1];
            s1_less_reg    <= head.less;
            s1_equal_reg   <= head.equal;
            s1_greater_reg <= head.greater;
            s1_dz_reg      <= head.div_zero;
        end
        if (s1_move)
        begin
            rsp_word_reg    <= word_b;
            rsp_less_reg    <= s1_less_reg;
            rsp_equal_reg   <= s1_equal_reg;
            rsp_greater_reg <= s1_greater_reg;
            rsp_dz_reg      <= s1_dz_reg;
        end
    end

    assign response.valid          = rsp_valid_reg;
    assign response.result_word    = rsp_word_reg;
    assign response.less_flag      = rsp_less_reg;
    assign response.equal_flag     = rsp_equal_reg;
    assign response.greater_flag   = rsp_greater_reg;
    assign response.divide_by_zero = rsp_dz_reg;

endmodule

@@ hw/rtl/fixed_point_alu_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fixed_point_alu_unit
// Signed fixed-point ALU: front classifier, queue, execution back end.
// ---------------------------------------------------------------------------
// most operations pass the queue, the first stage registers and the output register before a valid response
// throughput: one transaction per cycle while responses are taken, except divide
// a divide by a nonzero divisor holds the back end until the one-bit-per-cycle
// restoring divider has finished
// reset: asynchronous, clears queue pointers and count, pipeline valid state and divider control state only
module fixed_point_alu_unit
(
    input  logic      clk,
    input  logic      rst_n,
    fpa_req_if.sink   request,
    fpa_rsp_if.source response
);

    fpa_pkg::fpa_item_t item;
    fpa_pkg::fpa_item_t head;
    logic               push;
    logic               pop;
    logic               full;
    logic               empty;

    fpa_front u_front
    (
        .request    (request),
        .queue_full (full),
        .push       (push),
        .item       (item)
    );

    fpa_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (item),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    fpa_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (empty),
        .head        (head),
        .pop         (pop),
        .response    (response)
    );

endmodule
